// ===== sv/pce_pkg.sv =====
package pce_pkg;

    localparam int HEAD_LEN = 28;
    localparam int TAIL_LEN = 26;
    localparam int IDX_W    = 5;
    localparam int QDEPTH   = 2;

    localparam logic [8*HEAD_LEN-1:0] HEAD_TEXT = "-----BEGIN CERTIFICATE-----\n";
    localparam logic [8*TAIL_LEN-1:0] TAIL_TEXT = "\n-----END CERTIFICATE-----";
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [2:0] KEEP_TWO   = 3'd2;
    localparam logic [2:0] KEEP_THREE = 3'd3;
    localparam logic [2:0] KEEP_ALL   = 3'd4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       empty_cert;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_word;

    typedef struct packed {
        logic        head;
        logic        grp;
        logic [23:0] word;
        logic [2:0]  keep;
        logic        tail;
    } t_job;

    function automatic logic [7:0] head_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (int'(idx) < HEAD_LEN) begin
            c = HEAD_TEXT[8*(HEAD_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] tail_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (int'(idx) < TAIL_LEN) begin
            c = TAIL_TEXT[8*(TAIL_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return ALPHABET[8*(63-int'(v)) +: 8];
    endfunction

endpackage

// ===== sv/pce_front.sv =====
module pce_front
    import pce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    input  logic     i_full,
    output logic     o_push,
    output t_job     o_job
);

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_held,  n_held;
    logic        r_in_cert, n_in_cert;
    logic [1:0]  w_phase;
    logic [15:0] w_held;
    logic        w_accept;
    t_job        w_job;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_phase  = (r_in_cert && r_phase != 2'd3) ? r_phase : 2'd0;
    assign w_held   = r_in_cert ? r_held : 16'h0000;

    always_comb begin
        w_job      = '0;
        w_job.head = !r_in_cert;
        n_phase    = w_phase;
        n_held     = w_held;
        n_in_cert  = 1'b1;
        if (i_data.empty_cert) begin
            w_job.tail = 1'b1;
            if (w_phase == 2'd1) begin
                w_job.grp  = 1'b1;
                w_job.word = {w_held[15:8], 16'h0000};
                w_job.keep = KEEP_TWO;
            end else if (w_phase == 2'd2) begin
                w_job.grp  = 1'b1;
                w_job.word = {w_held, 8'h00};
                w_job.keep = KEEP_THREE;
            end
            n_phase   = 2'd0;
            n_held    = 16'h0000;
            n_in_cert = 1'b0;
        end else begin
            w_job.tail = i_data.last_byte;
            if (w_phase == 2'd1) begin
                n_held  = {w_held[15:8], i_data.byte_value};
                n_phase = 2'd2;
                if (i_data.last_byte) begin
                    w_job.grp  = 1'b1;
                    w_job.word = {w_held[15:8], i_data.byte_value, 8'h00};
                    w_job.keep = KEEP_THREE;
                end
            end else if (w_phase == 2'd2) begin
                w_job.grp  = 1'b1;
                w_job.word = {w_held, i_data.byte_value};
                w_job.keep = KEEP_ALL;
                n_held     = 16'h0000;
                n_phase    = 2'd0;
            end else begin
                n_held  = {i_data.byte_value, 8'h00};
                n_phase = 2'd1;
                if (i_data.last_byte) begin
                    w_job.grp  = 1'b1;
                    w_job.word = {i_data.byte_value, 16'h0000};
                    w_job.keep = KEEP_TWO;
                end
            end
            if (i_data.last_byte) begin
                n_phase   = 2'd0;
                n_held    = 16'h0000;
                n_in_cert = 1'b0;
            end
        end
    end

    assign o_job  = w_job;
    assign o_push = w_accept && (w_job.head || w_job.grp || w_job.tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 2'd0;
            r_held    <= 16'h0000;
            r_in_cert <= 1'b0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_in_cert <= n_in_cert;
        end
    end

endmodule

// ===== sv/pce_queue.sv =====
module pce_queue
    import pce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job       r_mem [QDEPTH];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(QDEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== sv/pce_back.sv =====
module pce_back
    import pce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    typedef enum logic [1:0] {
        SEG_HEAD,
        SEG_GRP,
        SEG_TAIL
    } t_seg;

    t_job             r_job;
    logic             r_act;
    t_seg             r_seg;
    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_out_word        r_data;

    logic             w_adv;
    logic [1:0]       w_k;
    logic [5:0]       w_sextet;
    t_out_word        w_out;
    logic             w_seg_end;

    assign w_adv = !r_valid || i_ready;
    assign o_pop = w_adv && !r_act && !i_empty;
    assign w_k   = r_idx[1:0];

    always_comb begin
        unique case (w_k)
            2'd0: w_sextet = r_job.word[23:18];
            2'd1: w_sextet = r_job.word[17:12];
            2'd2: w_sextet = r_job.word[11:6];
            2'd3: w_sextet = r_job.word[5:0];
        endcase
    end

    always_comb begin
        w_out     = '0;
        w_seg_end = 1'b0;
        unique case (r_seg)
            SEG_HEAD: begin
                w_out.out_char = head_char(r_idx);
                w_seg_end      = (r_idx == IDX_W'(HEAD_LEN - 1));
            end
            SEG_GRP: begin
                w_out.out_char = ({1'b0, w_k} < r_job.keep) ? b64_char(w_sextet) : PAD_CHAR;
                w_seg_end      = (w_k == 2'd3);
            end
            SEG_TAIL: begin
                w_out.out_char  = tail_char(r_idx);
                w_seg_end       = (r_idx == IDX_W'(TAIL_LEN - 1));
                w_out.last_char = w_seg_end;
            end
            default: begin
                w_out     = '0;
                w_seg_end = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_seg   <= SEG_HEAD;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= r_act;
            r_data  <= w_out;
            if (!r_act) begin
                if (!i_empty) begin
                    r_job <= i_job;
                    r_act <= i_job.head || i_job.grp || i_job.tail;
                    r_idx <= '0;
                    if (i_job.head) begin
                        r_seg <= SEG_HEAD;
                    end else if (i_job.grp) begin
                        r_seg <= SEG_GRP;
                    end else begin
                        r_seg <= SEG_TAIL;
                    end
                end
            end else if (w_seg_end) begin
                r_idx <= '0;
                priority if (r_seg == SEG_HEAD && r_job.grp) begin
                    r_seg <= SEG_GRP;
                end else if (r_seg != SEG_TAIL && r_job.tail) begin
                    r_seg <= SEG_TAIL;
                end else begin
                    r_act <= 1'b0;
                end
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/pem_certificate_base64_encoder.sv =====
// PEM certificate encoder.
// Input channel (i_valid / o_ready / i_data): one certificate byte per word,
// with last_byte marking the final byte and empty_cert ending a certificate
// without a byte of its own (a zero-length one if no byte came before).
// Output channel (o_valid / i_ready / o_data): one ASCII character per word;
// last_char is set on the final character of the END CERTIFICATE line.
// The first byte of a certificate brings the 28-character header line,
// every third byte four Base64 characters, and the last byte any padded
// short group and the 26-character trailer.
// A front stage classifies each byte and queues a job when output is due
// (up to two deep); the back stage plays a job out at one character per
// cycle while the receiver is ready, with an idle slot between jobs; a job
// passes through the queue and the job register to the output register.
// A receiver stall holds the output register and the back stage; the front
// keeps accepting bytes until the job queue is full.
// Reset empties the queue and returns to the state before a header.
module pem_certificate_base64_encoder
    import pce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    logic w_push, w_pop, w_full, w_empty;
    t_job w_job_in, w_job_out;

    pce_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    pce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== tb/sv/pem_text_checker.sv =====
`timescale 1ns / 1ps

module pem_text_checker
    import pce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    localparam int BEGIN_LEN = 28;
    localparam int END_LEN   = 26;

    localparam logic [8*BEGIN_LEN-1:0] BEGIN_LINE = "-----BEGIN CERTIFICATE-----\n";
    localparam logic [8*END_LEN-1:0]   END_LINE   = "\n-----END CERTIFICATE-----";
    localparam logic [8*64-1:0] B64_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [7:0] PAD_SIGN = 8'h3D;

    localparam int KEEP_ONE_BYTE  = 2;
    localparam int KEEP_TWO_BYTES = 3;
    localparam int KEEP_FULL      = 4;

    t_out_word   pem_chars_due[$];
    logic [1:0]  grp_count;
    logic [15:0] held_pair;
    logic        cert_open;
    int          fails;
    int          checked;

    task automatic push_text(input logic [8*BEGIN_LEN-1:0] txt, input int len,
                             input bit flag_end);
        t_out_word c;
        for (int k = 0; k < len; k++) begin
            c.out_char  = txt[8*(len-1-k) +: 8];
            c.last_char = flag_end && (k == len - 1);
            pem_chars_due.push_back(c);
        end
    endtask

    task automatic push_group(input logic [23:0] bits24, input int keep);
        t_out_word  c;
        logic [5:0] idx;
        for (int k = 0; k < 4; k++) begin
            idx         = bits24[18-6*k +: 6];
            c.out_char  = (k < keep) ? B64_SET[8*(63-int'(idx)) +: 8] : PAD_SIGN;
            c.last_char = 1'b0;
            pem_chars_due.push_back(c);
        end
    endtask

    task automatic close_cert();
        if (grp_count == 2'd1) begin
            push_group({held_pair[15:8], 16'h0000}, KEEP_ONE_BYTE);
        end else if (grp_count == 2'd2) begin
            push_group({held_pair, 8'h00}, KEEP_TWO_BYTES);
        end
        push_text((8*BEGIN_LEN)'(END_LINE), END_LEN, 1'b1);
        grp_count = 2'd0;
        held_pair = 16'h0000;
        cert_open = 1'b0;
    endtask

    task automatic encode_word(input t_in_word w);
        if (w.empty_cert) begin
            if (!cert_open) begin
                push_text(BEGIN_LINE, BEGIN_LEN, 1'b0);
            end
            close_cert();
        end else begin
            if (!cert_open) begin
                push_text(BEGIN_LINE, BEGIN_LEN, 1'b0);
                cert_open = 1'b1;
                grp_count = 2'd0;
                held_pair = 16'h0000;
            end
            case (grp_count)
                2'd1: begin
                    held_pair = {held_pair[15:8], w.byte_value};
                    grp_count = 2'd2;
                end
                2'd2: begin
                    push_group({held_pair, w.byte_value}, KEEP_FULL);
                    held_pair = 16'h0000;
                    grp_count = 2'd0;
                end
                default: begin
                    held_pair = {w.byte_value, 8'h00};
                    grp_count = 2'd1;
                end
            endcase
            if (w.last_byte) begin
                close_cert();
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word due;
        if (!i_rst_n) begin
            pem_chars_due.delete();
            grp_count = 2'd0;
            held_pair = 16'h0000;
            cert_open = 1'b0;
            fails     = 0;
            checked   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (pem_chars_due.size() == 0) begin
                    $error("out_char expected none, actual 8'h%02h", i_out_word.out_char);
                    fails++;
                end else begin
                    due = pem_chars_due.pop_front();
                    if (i_out_word.out_char !== due.out_char) begin
                        $error("out_char expected 8'h%02h, actual 8'h%02h",
                               due.out_char, i_out_word.out_char);
                        fails++;
                    end
                    if (i_out_word.last_char !== due.last_char) begin
                        $error("last_char expected %0b, actual %0b",
                               due.last_char, i_out_word.last_char);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                encode_word(i_in_word);
            end
        end
        o_pending    <= pem_chars_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== tb/sv/tb_pem_certificate_base64_encoder.sv =====
`timescale 1ns / 1ps

module tb_pem_certificate_base64_encoder;
    import pce_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 420;
    localparam int SETTLE       = 16;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    int fail_count;
    int pending;
    int checked;

    bit calm      = 1'b0;
    int hold_ask  = 0;
    int hold_done = 0;
    int rx_wait   = 0;

    int n_items  = 0;
    int n_certs  = 0;
    int n_empty  = 0;

    always #10 i_clk = ~i_clk;

    pem_certificate_base64_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    pem_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_word    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_word   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin : receiver
        int unsigned g;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else if (i_ready && o_valid) begin
            if (hold_ask != hold_done) begin
                hold_done <= hold_ask;
                rx_wait   <= HOLD_CYCLES;
                i_ready   <= 1'b0;
            end else begin
                g = calm ? 0 : $urandom_range(0, 14);
                if (g != 0) begin
                    i_ready <= 1'b0;
                    rx_wait <= g - 1;
                end
            end
        end else if (!i_ready) begin
            if (rx_wait == 0) begin
                i_ready <= 1'b1;
            end else begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic lst, input logic emp);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{byte_value: b, last_byte: lst, empty_cert: emp};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_items++;
    endtask

    task automatic send_cert(input int n_bytes, input bit by_flag);
        for (int k = 0; k < n_bytes; k++) begin
            send_word(8'($urandom_range(0, 255)), !by_flag && (k == n_bytes - 1), 1'b0);
        end
        if (by_flag || n_bytes == 0) begin
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
        n_certs++;
        if (n_bytes == 0) begin
            n_empty++;
        end
    endtask

    task automatic drain_outputs();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int item_goal;
        int r;
        bit mid_hold;
        mid_hold = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty certificates, with and without the last mark
        send_word(8'hA5, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        // two one-byte certificates, then two, three and four byte certificates
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h4D, 1'b0, 1'b0);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h6E, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        // end a certificate by the empty flag, one, two and no bytes held
        send_word(8'h12, 1'b0, 1'b0);
        send_word(8'h34, 1'b0, 1'b1);
        send_word(8'hAB, 1'b0, 1'b0);
        send_word(8'hCD, 1'b0, 1'b0);
        send_word(8'hEF, 1'b1, 1'b1);
        send_word(8'h01, 1'b0, 1'b0);
        send_word(8'h02, 1'b0, 1'b0);
        send_word(8'h03, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        n_certs += 10;
        n_empty += 2;
        drain_outputs();

        item_goal = n_items + RANDOM_ITEMS;
        // stall the receiver while a long certificate is offered
        hold_ask <= hold_ask + 1;
        send_cert(40, 1'b0);

        while (n_items < item_goal) begin
            if ($urandom_range(0, 5) == 0) begin
                calm <= !calm;
            end
            if (!mid_hold && n_items > item_goal - RANDOM_ITEMS / 2) begin
                mid_hold = 1'b1;
                hold_ask <= hold_ask + 1;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_cert(0, 1'b1);
            end else if (r < 14) begin
                send_cert($urandom_range(20, 48), r >= 12);
            end else begin
                send_cert($urandom_range(1, 12), r >= 90);
            end
            if ($urandom_range(0, 15) == 0) begin
                drain_outputs();
            end
        end

        drain_outputs();
        $display("Sent %0d words over %0d certificates (%0d empty), checked %0d characters",
                 n_items, n_certs, n_empty, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== pem_certificate_base64_encoder.f =====
sv/pce_pkg.sv
sv/pce_front.sv
sv/pce_queue.sv
sv/pce_back.sv
sv/pem_certificate_base64_encoder.sv
tb/sv/pem_text_checker.sv
tb/sv/tb_pem_certificate_base64_encoder.sv
